/* rtl/pooled_linked_list_engine_top_assert.svh */
// Assertion macros for the linked list engine
`ifndef POOLED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define POOLED_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define PLL_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pll check failed");
`define PLL_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pll check failed");
`endif

/* rtl/pll_pkg.sv */
// ----------------------------------------------------------------------------
// pll_pkg
// Types and constants of the pooled linked list engine.
// ----------------------------------------------------------------------------
package pll_pkg;
  localparam int PoolDepth   = 64;
  localparam int PayloadBits = 64;
  localparam int PtrW        = $clog2(PoolDepth) + 1;
  localparam int IdxW        = $clog2(PoolDepth);
  localparam logic [PtrW-1:0] NonePtr = PtrW'(PoolDepth);

  typedef enum logic [2:0] {
    OP_CLEAR, OP_SEARCH, OP_INS_FRONT, OP_INS_REAR,
    OP_POP_FRONT, OP_POP_BACK, OP_REMOVE, OP_READ
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NONE = 2'd1, ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_WALK, S_FIN, S_LINK, S_RDATA, S_OUT
  } fsm_t;
endpackage

/* rtl/pll_if.sv */
// ----------------------------------------------------------------------------
// pll_in_if / pll_out_if / pll_cfg_if
// Valid/ready channels of the linked list engine.
// ----------------------------------------------------------------------------
interface pll_in_if import pll_pkg::*; ();
  logic valid, ready;
  logic [2:0] op;
  logic [PayloadBits-1:0] payload;
  modport source (output valid, op, payload, input ready);
  modport sink (input valid, op, payload, output ready);
endinterface

interface pll_out_if import pll_pkg::*; ();
  logic valid, ready;
  logic [1:0] status;
  logic [IdxW-1:0] node_index;
  logic [PayloadBits-1:0] node_payload;
  modport source (output valid, status, node_index, node_payload, input ready);
  modport sink (input valid, status, node_index, node_payload, output ready);
endinterface

interface pll_cfg_if import pll_pkg::*; ();
  logic valid, ready;
  logic [PayloadBits-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/pooled_linked_list_engine_top.sv */
// Sequence: IDLE takes the word, WAIT and WALK run once per node a walk visits, FIN
// updates, LINK follows for an insert that finds a free slot and for a remove past the
// head, then RDATA and OUT register the result.
// Throughput: one word in flight; the next word is taken the cycle after the result is
// registered, and a result not yet taken holds the next one in its last state.
// Reset: synchronous; pointers go to none, nothing allocated, match mask all ones.
// ----------------------------------------------------------------------------
// pooled_linked_list_engine_top
// Linked list in a node pool with a free-list stack, one operation per word.
// ----------------------------------------------------------------------------
`include "pooled_linked_list_engine_top_assert.svh"
module pooled_linked_list_engine_top import pll_pkg::*; (
  input logic clk,
  input logic rst,
  pll_in_if.sink   in_ch,
  pll_out_if.source out_ch,
  pll_cfg_if.sink  cfg
);
  logic [PayloadBits-1:0] node_data [PoolDepth];
  logic [PtrW-1:0]        next_link [PoolDepth];
  logic [PtrW-1:0]        free_link [PoolDepth];

  logic [PtrW-1:0] head_ptr, current_ptr, free_head, high_water;
  logic [PayloadBits-1:0] match_mask;
  fsm_t state, state_next;
  op_t op;
  logic [PayloadBits-1:0] key;
  logic [PtrW-1:0] p, pre;
  logic [PtrW:0] steps;
  logic [PayloadBits-1:0] rd_data;
  logic [PtrW-1:0] rd_link, rd_free;
  logic [IdxW-1:0] rd_addr;
  logic [1:0] status;
  logic out_valid;
  logic can_alloc;
  logic [PtrW-1:0] new_slot;
  logic in_walk, walk_more, link_step, out_load;
  logic [PayloadBits-1:0] out_data;
  logic [IdxW-1:0] out_idx;
  logic [1:0] out_st;

  function automatic logic is_slot(logic [PtrW-1:0] x);
    return x < NonePtr;
  endfunction

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    rd_data <= node_data[rd_addr];
    rd_link <= next_link[rd_addr];
    rd_free <= free_link[rd_addr];
  end

  assign can_alloc = is_slot(free_head) || is_slot(high_water);
  assign new_slot = is_slot(free_head) ? free_head : high_water;
  assign in_walk = is_slot(p) && (steps < (PtrW+1)'(PoolDepth));
  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);
  // a second update step, LINK: pop the free stack and hook a rear node, or unlink current
  assign link_step = (status == ST_OK) &&
    (((op == OP_INS_FRONT || op == OP_INS_REAR) && can_alloc) ||
     (op == OP_REMOVE && current_ptr != head_ptr));

  // FIN reads the free stack top for inserts and current for remove
  always_comb begin
    unique case (state)
      S_FIN:
        rd_addr = (op == OP_INS_FRONT || op == OP_INS_REAR) ? free_head[IdxW-1:0]
                                                             : current_ptr[IdxW-1:0];
      S_LINK, S_RDATA, S_OUT: rd_addr = current_ptr[IdxW-1:0];
      default: rd_addr = p[IdxW-1:0];
    endcase
  end

  // rd_* hold node p in WALK
  always_comb begin
    unique case (op)
      OP_CLEAR: walk_more = in_walk;
      OP_SEARCH: walk_more = in_walk && (((rd_data ^ key) & match_mask) != '0);
      OP_INS_REAR, OP_POP_BACK: walk_more = in_walk && is_slot(rd_link);
      OP_REMOVE: walk_more = is_slot(head_ptr) && is_slot(current_ptr) &&
                             (current_ptr != head_ptr) && in_walk &&
                             (rd_link != current_ptr);
      default: walk_more = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_WAIT;
      S_WAIT: state_next = S_WALK;
      S_WALK: state_next = walk_more ? S_WAIT : S_FIN;
      S_FIN: state_next = link_step ? S_LINK : S_RDATA;
      S_LINK: state_next = S_RDATA;
      S_RDATA: state_next = S_OUT;
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= NonePtr; current_ptr <= NonePtr;
      free_head <= NonePtr; high_water <= '0;
      match_mask <= '1; out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (cfg.valid && cfg.ready) match_mask <= cfg.data;
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          op <= op_t'(in_ch.op);
          key <= in_ch.payload;
          p <= head_ptr; pre <= NonePtr; steps <= '0;
          status <= ST_OK;
        end
        S_WALK: begin
          if (walk_more) begin
            if (op == OP_CLEAR) begin
              free_link[p[IdxW-1:0]] <= free_head;
              free_head <= p;
            end
            pre <= p; p <= rd_link; steps <= steps + 1'b1;
          end else begin
            unique case (op)
              OP_CLEAR: begin
                head_ptr <= NonePtr; current_ptr <= NonePtr;
              end
              OP_SEARCH: if (in_walk) current_ptr <= p;
                else status <= ST_NONE;
              OP_REMOVE: if (!is_slot(head_ptr) || !is_slot(current_ptr) ||
                             (current_ptr != head_ptr && !in_walk)) status <= ST_NONE;
              default: ;
            endcase
          end
        end
        S_FIN: begin
          // rd_link = next of p, and p is the head unless a walk moved it
          unique case (op)
            OP_INS_FRONT, OP_INS_REAR: if (!can_alloc) status <= ST_FULL;
              else begin
                if (!is_slot(free_head)) high_water <= high_water + 1'b1;
                node_data[new_slot[IdxW-1:0]] <= key;
                current_ptr <= new_slot;
                next_link[new_slot[IdxW-1:0]] <= (op == OP_INS_FRONT) ? head_ptr : NonePtr;
                if (op == OP_INS_FRONT || !is_slot(head_ptr)) head_ptr <= new_slot;
              end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: if (status == ST_OK) begin
              if (!is_slot(head_ptr)) status <= ST_NONE;
              else if ((op == OP_POP_FRONT) || (op == OP_POP_BACK && !is_slot(pre)) ||
                       (op == OP_REMOVE && current_ptr == head_ptr)) begin
                free_link[head_ptr[IdxW-1:0]] <= free_head;
                free_head <= head_ptr;
                head_ptr <= rd_link;
                current_ptr <= rd_link;
              end else if (op == OP_POP_BACK) begin
                next_link[pre[IdxW-1:0]] <= NonePtr;
                free_link[p[IdxW-1:0]] <= free_head;
                free_head <= p;
                current_ptr <= pre;
              end
            end
            default: ;
          endcase
        end
        S_LINK: begin
          if (op == OP_REMOVE) begin
            // rd_link = next of current, p its predecessor
            next_link[p[IdxW-1:0]] <= rd_link;
            free_link[current_ptr[IdxW-1:0]] <= free_head;
            free_head <= current_ptr;
            current_ptr <= p;
          end else begin
            if (is_slot(free_head)) free_head <= rd_free;
            if (op == OP_INS_REAR && is_slot(p)) next_link[p[IdxW-1:0]] <= current_ptr;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (status == ST_OK && is_slot(current_ptr)) begin
        out_st <= ST_OK; out_idx <= current_ptr[IdxW-1:0]; out_data <= rd_data;
      end else begin
        out_st <= (status == ST_OK) ? ST_NONE : status;
        out_idx <= '0; out_data <= '0;
      end
    end
  end
  assign out_ch.valid = out_valid;
  assign out_ch.status = out_st;
  assign out_ch.node_index = out_idx;
  assign out_ch.node_payload = out_data;

  `PLL_ASSERT_NEXT(a_out_hold, out_valid && !out_ch.ready, out_valid && $stable(out_data))
  `PLL_ASSERT_NEXT(a_take, in_ch.valid && in_ch.ready, state == S_WAIT)
  `PLL_ASSERT_IMPL(a_st_range, out_valid, out_st != 2'd3)
endmodule

/* test/tb_pooled_linked_list_engine_top.sv */
// ----------------------------------------------------------------------------
// Testbench of the pooled linked list engine
// Drives list operations through the input channel with random gaps, predicts
// each result with a behavioral model of the node pool, and compares every
// result word field by field. Covers mask settings, pool exhaustion, empty
// list cases and output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_pooled_linked_list_engine_top;
  import pll_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  node_index;
    logic [63:0] node_payload;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  pll_in_if  in_ch ();
  pll_out_if out_ch ();
  pll_cfg_if cfg ();

  pooled_linked_list_engine_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  // model state
  logic [63:0] pool_data [PoolDepth];
  logic [6:0]  pool_next [PoolDepth];
  logic [6:0]  pool_free [PoolDepth];
  logic [6:0]  list_head, cur_node, fresh_mark, free_top;
  logic [63:0] key_mask;
  int          list_len;

  result_t expected_q[$];
  int      error_count = 0;
  int      result_count = 0;
  int      hold_off = 0;
  bit      long_hold = 0;

  function automatic bit valid_slot(logic [6:0] p);
    return p < PoolDepth;
  endfunction

  function automatic logic [6:0] grab_slot();
    logic [6:0] s;
    if (valid_slot(free_top)) begin
      s = free_top;
      free_top = pool_free[s];
    end else begin
      s = fresh_mark;
      fresh_mark++;
    end
    return s;
  endfunction

  function automatic void release_slot(logic [6:0] s);
    pool_free[s] = free_top;
    free_top = s;
  endfunction

  function automatic void unlink_head();
    logic [6:0] nx;
    nx = pool_next[list_head];
    release_slot(list_head);
    list_head = nx;
    cur_node = nx;
    list_len--;
  endfunction

  function automatic result_t apply_op(op_t op, logic [63:0] data);
    result_t r;
    logic [1:0] st;
    logic [6:0] p, pre, s;
    bit hit;
    st = ST_OK;
    case (op)
      OP_CLEAR: begin
        while (valid_slot(list_head)) unlink_head();
        cur_node = NonePtr;
      end
      OP_SEARCH: begin
        p = list_head;
        hit = 0;
        for (int k = 0; k < PoolDepth && valid_slot(p); k++) begin
          if (((pool_data[p] ^ data) & key_mask) == 0) begin
            hit = 1;
            break;
          end
          p = pool_next[p];
        end
        if (hit) cur_node = p;
        else st = ST_NONE;
      end
      OP_INS_FRONT, OP_INS_REAR: begin
        if (!valid_slot(free_top) && fresh_mark >= PoolDepth) begin
          st = ST_FULL;
        end else if (op == OP_INS_FRONT || !valid_slot(list_head)) begin
          s = grab_slot();
          pool_data[s] = data;
          pool_next[s] = list_head;
          list_head = s;
          cur_node = s;
          list_len++;
        end else begin
          p = list_head;
          while (valid_slot(pool_next[p])) p = pool_next[p];
          s = grab_slot();
          pool_data[s] = data;
          pool_next[s] = NonePtr;
          pool_next[p] = s;
          cur_node = s;
          list_len++;
        end
      end
      OP_POP_FRONT: begin
        if (!valid_slot(list_head)) st = ST_NONE;
        else unlink_head();
      end
      OP_POP_BACK: begin
        if (!valid_slot(list_head)) st = ST_NONE;
        else if (!valid_slot(pool_next[list_head])) unlink_head();
        else begin
          p = list_head;
          pre = NonePtr;
          while (valid_slot(pool_next[p])) begin
            pre = p;
            p = pool_next[p];
          end
          pool_next[pre] = NonePtr;
          release_slot(p);
          cur_node = pre;
          list_len--;
        end
      end
      OP_REMOVE: begin
        if (!valid_slot(list_head) || !valid_slot(cur_node)) st = ST_NONE;
        else if (cur_node == list_head) unlink_head();
        else begin
          p = list_head;
          hit = 0;
          for (int k = 0; k < PoolDepth && valid_slot(p); k++) begin
            if (pool_next[p] == cur_node) begin
              hit = 1;
              break;
            end
            p = pool_next[p];
          end
          if (hit) begin
            pool_next[p] = pool_next[cur_node];
            release_slot(cur_node);
            cur_node = p;
            list_len--;
          end else st = ST_NONE;
        end
      end
      default: ;
    endcase
    if (st == ST_OK && !valid_slot(cur_node)) st = ST_NONE;
    r.status = st;
    r.node_index = (st == ST_OK) ? cur_node[5:0] : '0;
    r.node_payload = (st == ST_OK) ? pool_data[cur_node] : '0;
    return r;
  endfunction

  function automatic int gap_len();
    int g;
    g = $urandom_range(0, 99);
    if (g < 45) return 0;
    if (g < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid stays high after a taken word until the next falling edge
  task automatic send_op(op_t op, logic [63:0] data);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.payload <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(apply_op(op, data));
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_mask(logic [63:0] m);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= m;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    key_mask = m;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // receiver with random stalls; long_hold forces a long stretch of no ready
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (long_hold) out_ch.ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      hold_off <= gap_len();
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.node_index, out_ch.node_payload};
      result_count++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.node_index != want.node_index) begin
          $display("%0t: node_index expected %0d actual %0d", $time,
                   want.node_index, got.node_index);
          error_count++;
        end
        if (got.node_payload != want.node_payload) begin
          $display("%0t: node_payload expected %h actual %h", $time,
                   want.node_payload, got.node_payload);
          error_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // keys mostly come from a small set so that searches hit
  function automatic logic [63:0] pick_value();
    if ($urandom_range(0, 3) == 0) return rand64();
    return {$urandom_range(0, 3) == 0 ? 32'hffff_ffff : 32'h0, 28'h0, 4'($urandom_range(0, 15))};
  endfunction

  task automatic test_directed();
    send_op(OP_READ, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_REMOVE, '0);
    send_op(OP_SEARCH, '0);
    send_op(OP_INS_FRONT, '1);
    send_op(OP_INS_REAR, '0);
    send_op(OP_INS_REAR, 64'h5555_aaaa_5555_aaaa);
    send_op(OP_SEARCH, '1);
    send_op(OP_READ, '0);
    send_op(OP_REMOVE, '0);
    send_op(OP_REMOVE, '0);
    send_op(OP_SEARCH, 64'h1234);
    send_op(OP_POP_BACK, '0);
    send_op(OP_INS_FRONT, 64'h8000_0000_0000_0001);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_CLEAR, '0);
    send_op(OP_REMOVE, '0);
    send_op(OP_CLEAR, '0);
  endtask

  // fill the pool past its end, then empty it from the back
  task automatic test_pool_full();
    for (int i = 0; i < PoolDepth + 3; i++)
      send_op($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR, rand64());
    for (int i = 0; i < PoolDepth + 1; i++) send_op(OP_POP_BACK, '0);
  endtask

  // stall the receiver long enough for the input to back up
  task automatic test_back_pressure();
    fork
      begin
        long_hold = 1;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end
      for (int i = 0; i < 12; i++) send_op(OP_INS_FRONT, pick_value());
    join
    send_op(OP_CLEAR, '0);
  endtask

  task automatic test_random(int count);
    op_t op;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_CLEAR;
      else if (r < 20) op = OP_SEARCH;
      else if (r < 40) op = (list_len < 20) ? OP_INS_FRONT : OP_POP_FRONT;
      else if (r < 55) op = (list_len < 20) ? OP_INS_REAR : OP_POP_BACK;
      else op = op_t'($urandom_range(1, 7));
      send_op(op, (r < 1) ? '0 : pick_value());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_READ;
    in_ch.payload = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    list_head = NonePtr;
    cur_node = NonePtr;
    free_top = NonePtr;
    fresh_mark = '0;
    key_mask = '1;
    list_len = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_full();
    test_back_pressure();
    test_random(120);
    write_mask(64'h0000_0000_0000_000f);
    test_random(150);
    write_mask('0);
    test_random(80);
    write_mask(64'hffff_ffff_0000_0000);
    test_random(120);
    write_mask(rand64());
    test_random(60);
    write_mask('1);
    test_random(60);
    drain();
    $display("Ran all eight operations over %0d results with five mask settings,",
             result_count);
    $display("including pool exhaustion, empty-list cases and a long output stall.");
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/pll_pkg.sv
rtl/pll_if.sv
rtl/pooled_linked_list_engine_top.sv
test/tb_pooled_linked_list_engine_top.sv
